FILE: src/tcw_pkg.sv
// shared constants, types and helpers for the text console writer
// no dependencies; imported by tcw_ram users, tcw_put_step and text_console_writer
package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int CELL_W  = 16;

    // command codes
    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_SET   = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    // special characters
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_RETURN    = 8'd13;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    localparam logic [7:0]        RESET_COLOR = 8'h07;
    localparam logic [CELL_W-1:0] RESET_CELL  = {RESET_COLOR, CH_SPACE};

    // result of one put-character step
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [CELL_W-1:0] data;
        logic [6:0]        col;
        logic [4:0]        row;
        logic              scroll;
    } t_put_step;

    // linear cell address of a cursor position
    function automatic logic [ADDR_W-1:0] tcw_lin(input logic [4:0] row,
                                                  input logic [6:0] col);
        return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    endfunction

endpackage

FILE: src/tcw_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/tcw_put_step.sv
// cursor update and cell write for one put-character command
// depends on tcw_pkg
module tcw_put_step
    import tcw_pkg::*;
(
    input  logic [6:0] i_col,
    input  logic [4:0] i_row,
    input  logic [7:0] i_char,
    input  logic [7:0] i_color,
    output t_put_step  o_step
);

    logic [ADDR_W-1:0] here;
    logic [6:0]        col_n;
    logic [4:0]        row_n;

    always_comb begin
        here          = tcw_lin(i_row, i_col);
        col_n         = i_col;
        row_n         = i_row;
        o_step.we     = 1'b0;
        o_step.addr   = here;
        o_step.data   = {i_color, i_char};
        o_step.scroll = 1'b0;
        case (i_char)
            CH_NEWLINE: begin
                col_n = '0;
                row_n = i_row + 5'd1;
            end
            CH_RETURN: begin
                col_n = '0;
            end
            CH_TAB: begin
                col_n = (i_col + 7'd4) & ~7'd3;
            end
            CH_BACKSPACE: begin
                if (i_col != '0) begin
                    col_n       = i_col - 7'd1;
                    o_step.we   = 1'b1;
                    o_step.addr = here - ADDR_W'(1);
                    o_step.data = {i_color, CH_SPACE};
                end
            end
            default: begin
                o_step.we = 1'b1;
                col_n     = i_col + 7'd1;
            end
        endcase
        // wrap at the right edge
        if (col_n >= 7'(COLUMNS)) begin
            col_n = '0;
            row_n = row_n + 5'd1;
        end
        // past the bottom row: scroll
        if (row_n >= 5'(ROWS)) begin
            row_n         = 5'(ROWS - 1);
            o_step.scroll = 1'b1;
        end
        o_step.col = col_n;
        o_step.row = row_n;
    end

endmodule

FILE: src/text_console_writer.sv
// top level of the text console writer: command sequencer over the cell store
// depends on tcw_pkg, tcw_ram, tcw_put_step
//
//  channel  direction  handshake                  contents
//  s_axis   in         s_axis_tvalid/tready       command word: tuser cmd, tdata operands
//  m_axis   out        m_axis_tvalid/tready       result word: cursor, position, cell
//  cfg      in         i_cfg_we                   color attribute byte
//
// put character, set cursor and read cell pass from accept through the done state into the output register
// a put that scrolls first copies the rows up by one, then blanks the bottom row
// clear screen blanks every cell, one cell write per cycle through the ram write port
// after reset a clearing pass fills the store with blanks; no word is taken
// a word is taken whenever the sequencer is idle, even while a result still waits
// a finished result waits in the sequencer until the output register is free
module text_console_writer
    import tcw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    // command stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
    input  logic [31:0] s_axis_tdata,   // [7:0] character, [14:8] new_column,
                                        // [19:15] new_row, [30:20] cell_index, [31] zero
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // [6:0] column, [11:7] row,
                                        // [22:12] cursor_position, [38:23] cell_value,
                                        // [39] zero
);

    // sequencer states
    localparam logic [1:0] S_FILL = 2'd0;   // blank a range of cells
    localparam logic [1:0] S_IDLE = 2'd1;   // ready for a command word
    localparam logic [1:0] S_COPY = 2'd2;   // move rows up by one
    localparam logic [1:0] S_DONE = 2'd3;   // result ready for the output register

    logic [1:0]        r_state;
    logic [ADDR_W-1:0] r_cnt;
    logic [CELL_W-1:0] r_fill;
    logic              r_init;
    logic [6:0]        r_col;
    logic [4:0]        r_row;
    logic [7:0]        r_color;
    logic              r_cell_ok;
    logic              r_m_tvalid;
    logic [39:0]       r_m_tdata;

    // unpacked command word
    logic [1:0]        in_cmd;
    logic [7:0]        in_char;
    logic [6:0]        in_col;
    logic [4:0]        in_row;
    logic [ADDR_W-1:0] in_idx;
    logic              accept;

    // ram port
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    t_put_step         step;
    logic              out_free;
    logic [CELL_W-1:0] cell_out;

    assign in_cmd  = s_axis_tuser;
    assign in_char = s_axis_tdata[7:0];
    assign in_col  = s_axis_tdata[14:8];
    assign in_row  = s_axis_tdata[19:15];
    assign in_idx  = s_axis_tdata[30:20];

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_tvalid || m_axis_tready;
    assign cell_out      = r_cell_ok ? ram_rdata : '0;

    tcw_put_step u_step (
        .i_col   (r_col),
        .i_row   (r_row),
        .i_char  (in_char),
        .i_color (r_color),
        .o_step  (step)
    );

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ram access: the copy reads a row and a cell ahead of the write, so the two never meet;
    // every other access happens only while nothing else is in flight
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_cnt;
        ram_wdata = r_fill;
        ram_re    = 1'b0;
        ram_raddr = r_cnt + ADDR_W'(COLUMNS);
        case (r_state)
            S_FILL: begin
                ram_we = 1'b1;
            end
            S_COPY: begin
                ram_re    = (r_cnt < ADDR_W'(CELLS - COLUMNS));
                ram_we    = (r_cnt != '0);
                ram_waddr = r_cnt - ADDR_W'(1);
                ram_wdata = ram_rdata;
            end
            S_IDLE: begin
                if (accept && in_cmd == CMD_PUT) begin
                    ram_we    = step.we;
                    ram_waddr = step.addr;
                    ram_wdata = step.data;
                end
                if (accept && in_cmd == CMD_READ) begin
                    ram_re    = (in_idx < ADDR_W'(CELLS));
                    ram_raddr = in_idx;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_FILL;
            r_cnt      <= '0;
            r_fill     <= RESET_CELL;
            r_init     <= 1'b1;
            r_col      <= '0;
            r_row      <= '0;
            r_color    <= RESET_COLOR;
            r_cell_ok  <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_color <= i_cfg_wdata;
            end

            // a finished result refills the output register as it empties
            if (r_state == S_DONE && out_free) begin
                r_m_tvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_tvalid <= 1'b0;
            end

            case (r_state)
                S_FILL: begin
                    if (r_cnt == ADDR_W'(CELLS - 1)) begin
                        r_init  <= 1'b0;
                        r_state <= r_init ? S_IDLE : S_DONE;
                    end else begin
                        r_cnt <= r_cnt + ADDR_W'(1);
                    end
                end
                S_COPY: begin
                    // the last copy write leaves r_cnt at the bottom row start
                    if (r_cnt == ADDR_W'(CELLS - COLUMNS)) begin
                        r_fill  <= {r_color, CH_SPACE};
                        r_state <= S_FILL;
                    end else begin
                        r_cnt <= r_cnt + ADDR_W'(1);
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_cell_ok <= 1'b0;
                        r_state   <= S_DONE;
                        case (in_cmd)
                            CMD_PUT: begin
                                r_col <= step.col;
                                r_row <= step.row;
                                if (step.scroll) begin
                                    r_cnt   <= '0;
                                    r_state <= S_COPY;
                                end
                            end
                            CMD_CLEAR: begin
                                r_col   <= '0;
                                r_row   <= '0;
                                r_cnt   <= '0;
                                r_fill  <= {r_color, CH_SPACE};
                                r_state <= S_FILL;
                            end
                            CMD_SET: begin
                                r_col <= (in_col < 7'(COLUMNS)) ? in_col : 7'(COLUMNS - 1);
                                r_row <= (in_row < 5'(ROWS)) ? in_row : 5'(ROWS - 1);
                            end
                            CMD_READ: begin
                                r_cell_ok <= (in_idx < ADDR_W'(CELLS));
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result payload, loaded together with the valid flag
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_m_tdata <= {1'b0, cell_out, tcw_lin(r_row, r_col), r_row, r_col};
        end
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;

`ifndef SYNTHESIS
    // cursor stays on the screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col < 7'(COLUMNS) && r_row < 5'(ROWS))
        else $error("cursor off screen");

    // no write beyond the store
    a_write_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ram_waddr < ADDR_W'(CELLS))
        else $error("cell write out of range");

    // the row copy never reads the cell it writes
    a_copy_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY && ram_re && ram_we) |-> ram_raddr != ram_waddr)
        else $error("row copy read and write collide");

    // an accepted word always leaves the idle state
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state != S_IDLE)
        else $error("sequencer stayed idle after accept");

    // a result is presented only after the sequencer finished a command
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_tvalid) |-> $past(r_state) == S_DONE)
        else $error("result without finished command");
`endif

endmodule

FILE: sim/tcw_console_check.sv
// result checker for the text console writer: keeps its own cell store and cursor
// predicts one result word per command and compares it with the result stream
// depends on tcw_pkg
module tcw_console_check
    import tcw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_cmd_valid,
    input  logic        i_cmd_ready,
    input  logic [1:0]  i_cmd_user,    // [1:0] cmd
    input  logic [31:0] i_cmd_data,    // [7:0] character, [14:8] new_column,
                                       // [19:15] new_row, [30:20] cell_index, [31] zero
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [39:0] i_res_data,    // [6:0] column, [11:7] row,
                                       // [22:12] cursor_position, [38:23] cell_value
    output int          o_errors,
    output int          o_pending,
    output logic [10:0] o_cursor_pos
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        pad;
        logic [15:0] cell_value;
        logic [10:0] position;
        logic [4:0]  row;
        logic [6:0]  column;
    } t_report;

    logic [CELL_W-1:0] shadow [CELLS];
    int unsigned       cur_col;
    int unsigned       cur_row;
    logic [7:0]        attr;
    t_report           cursor_reports_q [$];
    int                error_count;

    function automatic logic [CELL_W-1:0] blank_word();
        return {attr, CH_SPACE};
    endfunction

    function automatic void put_char(input logic [7:0] ch);
        int unsigned here;
        int unsigned i;
        here = cur_row * COLUMNS + cur_col;
        if (ch == CH_NEWLINE) begin
            cur_col = 0;
            cur_row++;
        end else if (ch == CH_RETURN) begin
            cur_col = 0;
        end else if (ch == CH_TAB) begin
            cur_col = (cur_col + 4) & ~32'd3;
        end else if (ch == CH_BACKSPACE) begin
            // backspace stays on the same row
            if (cur_col > 0) begin
                cur_col--;
                shadow[here - 1] = blank_word();
            end
        end else begin
            shadow[here] = {attr, ch};
            cur_col++;
        end
        if (cur_col >= COLUMNS) begin
            cur_col = 0;
            cur_row++;
        end
        // scroll up one row, fresh blank bottom row
        if (cur_row >= ROWS) begin
            for (i = 0; i < (ROWS - 1) * COLUMNS; i++)
                shadow[i] = shadow[i + COLUMNS];
            for (i = (ROWS - 1) * COLUMNS; i < CELLS; i++)
                shadow[i] = blank_word();
            cur_row = ROWS - 1;
        end
    endfunction

    function automatic t_report apply_command(input logic [1:0] cmd, input logic [31:0] data);
        int unsigned ncol;
        int unsigned nrow;
        int unsigned idx;
        int unsigned i;
        t_report     r;
        ncol = 32'(data[14:8]);
        nrow = 32'(data[19:15]);
        idx  = 32'(data[30:20]);
        r    = '0;
        case (cmd)
            CMD_PUT: put_char(data[7:0]);
            CMD_CLEAR: begin
                for (i = 0; i < CELLS; i++)
                    shadow[i] = blank_word();
                cur_col = 0;
                cur_row = 0;
            end
            CMD_SET: begin
                cur_col = (ncol < COLUMNS) ? ncol : COLUMNS - 1;
                cur_row = (nrow < ROWS) ? nrow : ROWS - 1;
            end
            default: begin
                if (idx < CELLS)
                    r.cell_value = shadow[idx];
            end
        endcase
        r.column   = 7'(cur_col);
        r.row      = 5'(cur_row);
        r.position = 11'(cur_row * COLUMNS + cur_col);
        return r;
    endfunction

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_report got;
        t_report want;
        if (!i_rst_n) begin
            foreach (shadow[k])
                shadow[k] = RESET_CELL;
            cur_col = 0;
            cur_row = 0;
            attr    = RESET_COLOR;
            cursor_reports_q.delete();
            error_count = 0;
        end else begin
            if (i_cfg_we)
                attr = i_cfg_wdata;
            // results first: a word accepted on this edge cannot be answered yet
            if (i_res_valid && i_res_ready) begin
                got = t_report'(i_res_data);
                if (cursor_reports_q.size() == 0) begin
                    error_count++;
                    $display("%0t: result word, expected none, got %h", $time, got);
                end else begin
                    want = cursor_reports_q.pop_front();
                    check_field("column", 32'(want.column), 32'(got.column));
                    check_field("row", 32'(want.row), 32'(got.row));
                    check_field("cursor_position", 32'(want.position), 32'(got.position));
                    check_field("cell_value", 32'(want.cell_value), 32'(got.cell_value));
                end
            end
            if (i_cmd_valid && i_cmd_ready)
                cursor_reports_q.push_back(apply_command(i_cmd_user, i_cmd_data));
        end
        o_errors     <= error_count;
        o_pending    <= cursor_reports_q.size();
        o_cursor_pos <= 11'(cur_row * COLUMNS + cur_col);
    end

endmodule

FILE: sim/tb.sv
// top of the text console writer testbench: clock, reset, command stimulus, color writes
// depends on tcw_pkg, text_console_writer and tcw_console_check
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tcw_pkg::*;

    // cycles with no word moved on any channel before the run is given up;
    // the longest legal quiet stretch is a clearing pass or a scroll
    localparam int WATCHDOG_LIMIT = 12000;
    localparam int PHASES         = 6;
    localparam int PHASE_WORDS    = 275;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [7:0]  cfg_wdata     = '0;
    logic        cmd_valid     = 1'b0;
    logic [1:0]  cmd_user      = '0;    // [1:0] cmd
    logic [31:0] cmd_data      = '0;    // [7:0] character, [14:8] new_column,
                                        // [19:15] new_row, [30:20] cell_index, [31] zero
    logic        res_ready     = 1'b0;
    wire         cmd_ready;
    wire         res_valid;
    wire  [39:0] res_data;              // [6:0] column, [11:7] row,
                                        // [22:12] cursor_position, [38:23] cell_value

    int          errors;
    int          pending;
    logic [10:0] cursor_pos;
    int unsigned rx_hold       = 0;
    int unsigned quiet_cycles  = 0;
    // set for stretches where neither side inserts idle cycles
    bit          no_idle       = 1'b0;

    always #5 i_clk = ~i_clk;

    text_console_writer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .s_axis_tvalid (cmd_valid),
        .s_axis_tready (cmd_ready),
        .s_axis_tuser  (cmd_user),
        .s_axis_tdata  (cmd_data),
        .m_axis_tvalid (res_valid),
        .m_axis_tready (res_ready),
        .m_axis_tdata  (res_data)
    );

    tcw_console_check checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_cmd_valid  (cmd_valid),
        .i_cmd_ready  (cmd_ready),
        .i_cmd_user   (cmd_user),
        .i_cmd_data   (cmd_data),
        .i_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .i_res_data   (res_data),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_cursor_pos (cursor_pos)
    );

    // idle cycles before the next word on either side
    function automatic int unsigned idle_cycles();
        return no_idle ? 0 : $urandom_range(0, 5);
    endfunction

    // result side: after each accepted word, hold tready low for a random stall
    always @(posedge i_clk) begin
        int unsigned hold;
        if (!i_rst_n) begin
            res_ready <= 1'b0;
            rx_hold   <= 0;
        end else if (res_valid && res_ready) begin
            hold = idle_cycles();
            rx_hold   <= hold;
            res_ready <= (hold == 0);
        end else if (rx_hold > 0) begin
            rx_hold   <= rx_hold - 1;
            res_ready <= (rx_hold == 1);
        end else begin
            res_ready <= 1'b1;
        end
    end

    // watchdog: nothing moving for too long means a hang or a lost result
    always @(posedge i_clk) begin
        if ((cmd_valid && cmd_ready) || (res_valid && res_ready) || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one command word; tvalid stays high into the next word when no gap is drawn
    task automatic send_word(input logic [1:0] cmd, input logic [7:0] ch,
                             input logic [6:0] ncol, input logic [4:0] nrow,
                             input logic [10:0] idx);
        int unsigned gap;
        gap = idle_cycles();
        if (gap > 0) begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_valid <= 1'b1;
        cmd_user  <= cmd;
        cmd_data  <= {1'b0, idx, nrow, ncol, ch};
        do @(posedge i_clk); while (!cmd_ready);
    endtask

    // stop sending and let every result come back; set_color then writes the color register
    task automatic drain();
        cmd_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_color(input logic [7:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // mostly printable text with control bytes mixed in; cursor moves lean
    // toward the bottom rows so that scrolling happens often
    task automatic random_word();
        int unsigned pick;
        logic [1:0]  cmd;
        logic [7:0]  ch;
        logic [6:0]  ncol;
        logic [4:0]  nrow;
        logic [10:0] idx;
        ch   = 8'($urandom);
        ncol = 7'($urandom);
        nrow = 5'($urandom);
        idx  = 11'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 74)
            cmd = CMD_PUT;
        else if (pick < 84)
            cmd = CMD_SET;
        else if (pick < 97)
            cmd = CMD_READ;
        else
            cmd = CMD_CLEAR;
        case (cmd)
            CMD_PUT: begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    ch = 8'($urandom_range(8'h21, 8'h7e));
                else if (pick < 63)
                    ch = CH_NEWLINE;
                else if (pick < 67)
                    ch = CH_RETURN;
                else if (pick < 73)
                    ch = CH_TAB;
                else if (pick < 82)
                    ch = CH_BACKSPACE;
            end
            CMD_SET: begin
                if ($urandom_range(0, 1))
                    nrow = 5'($urandom_range(20, 31));
                if ($urandom_range(0, 2) == 0)
                    ncol = 7'($urandom_range(72, 127));
            end
            CMD_READ: begin
                // read back what was just written, near the cursor
                if ($urandom_range(0, 2) != 0)
                    idx = cursor_pos - 11'($urandom_range(0, 12));
            end
            default: ;
        endcase
        send_word(cmd, ch, ncol, nrow, idx);
    endtask

    initial begin
        int ph;
        int n;

        // reset, then wait out the clearing pass before anything else
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk); while (!cmd_ready);

        // directed: reset contents at the default color, edges of the store
        send_word(CMD_READ, 8'h00, 7'd0, 5'd0, 11'd0);
        send_word(CMD_READ, 8'h00, 7'd0, 5'd0, 11'd1999);
        send_word(CMD_READ, 8'h00, 7'd0, 5'd0, 11'd2000);    // just past the store
        send_word(CMD_READ, 8'h00, 7'd0, 5'd0, 11'h7ff);
        // lowest and highest bytes are written like any other
        send_word(CMD_PUT, 8'h41, 7'd0, 5'd0, 11'd0);
        send_word(CMD_PUT, 8'h00, 7'd0, 5'd0, 11'd0);
        send_word(CMD_PUT, 8'hff, 7'd0, 5'd0, 11'd0);
        send_word(CMD_PUT, CH_BACKSPACE, 7'd0, 5'd0, 11'd0);
        send_word(CMD_READ, 8'h00, 7'd0, 5'd0, 11'd2);      // blanked by backspace
        send_word(CMD_PUT, CH_TAB, 7'd0, 5'd0, 11'd0);
        send_word(CMD_PUT, CH_RETURN, 7'd0, 5'd0, 11'd0);
        // backspace at column zero does nothing
        send_word(CMD_PUT, CH_BACKSPACE, 7'd0, 5'd0, 11'd0);
        send_word(CMD_PUT, CH_NEWLINE, 7'd0, 5'd0, 11'd0);
        // out-of-range cursor saturates to the last cell, then wrap plus scroll
        send_word(CMD_SET, 8'h00, 7'h7f, 5'h1f, 11'd0);
        send_word(CMD_PUT, 8'h5a, 7'd0, 5'd0, 11'd0);
        send_word(CMD_READ, 8'h00, 7'd0, 5'd0, 11'd1919);
        // tab that runs off the end of a row
        send_word(CMD_SET, 8'h00, 7'd76, 5'd3, 11'd0);
        send_word(CMD_PUT, CH_TAB, 7'd0, 5'd0, 11'd0);
        // newline on the last row scrolls
        send_word(CMD_SET, 8'h00, 7'd0, 5'd24, 11'd0);
        send_word(CMD_PUT, CH_NEWLINE, 7'd0, 5'd0, 11'd0);
        // printable byte in the last column wraps
        send_word(CMD_SET, 8'h00, 7'd79, 5'd0, 11'd0);
        send_word(CMD_PUT, 8'h7e, 7'd0, 5'd0, 11'd0);
        // clear ignores its operands
        send_word(CMD_CLEAR, 8'hff, 7'h7f, 5'h1f, 11'h7ff);
        send_word(CMD_READ, 8'h00, 7'd0, 5'd0, 11'd1999);
        send_word(CMD_SET, 8'h00, 7'd0, 5'd0, 11'd0);

        // random phases, each under its own color, extremes first
        for (ph = 0; ph < PHASES; ph++) begin
            if (ph == 0)
                set_color(8'hff);
            else if (ph == 1)
                set_color(8'h00);
            else
                set_color(8'($urandom_range(0, 255)));
            for (n = 0; n < PHASE_WORDS; n++) begin
                if (n % 50 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                random_word();
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
